// File: sv/rwmc_pkg.sv
// shared types and constants for the random walk maze carver
`timescale 1ns / 1ps

package rwmc_pkg;

  // grid geometry
  localparam int MAX_SIZE = 64;
  localparam int MIN_SIZE = 3;
  localparam int STRIDE   = 2;
  localparam int ROW_AW   = $clog2(MAX_SIZE);

  // field widths
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int COUNT_W = 11;
  localparam int HALF_W  = 6;

  localparam logic [SIZE_W-1:0]  GRID_SIZE_RESET = SIZE_W'(21);
  localparam logic [COORD_W-1:0] START_COL_RESET = COORD_W'(21 / 2);

  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_STEP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] direction;
  } in_req_t;

  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] wall_row;
    logic [COORD_W-1:0] wall_col;
    logic [COUNT_W-1:0] remaining;
    logic               done_res;
  } out_res_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

// File: sv/rwmc_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rwmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rwmc_ctrl.sv
// request sequencing state machine and result valid flag
`timescale 1ns / 1ps

module rwmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rwmc_pkg::ctrl_cmd_t cmd
);

  rwmc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             capture;
  logic             execute;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwmc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // outputs
  always_comb begin
    in_ready = (state_r == rwmc_pkg::ST_IDLE);
    capture  = in_valid && in_ready;
    // finish only when the result register is free or draining
    execute  = (state_r == rwmc_pkg::ST_CHECK) && (!out_valid_r || out_ready);
    cmd.capture = capture;
    cmd.execute = execute;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rwmc_pkg::ST_IDLE: begin
        if (capture) begin
          state_nxt = rwmc_pkg::ST_CHECK;
        end
      end
      rwmc_pkg::ST_CHECK: begin
        if (execute) begin
          state_nxt = rwmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rwmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/rwmc_datapath.sv
// walker position, cell count, grid store and result register
`timescale 1ns / 1ps

module rwmc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rwmc_pkg::ctrl_cmd_t                 cmd,
  input  rwmc_pkg::in_req_t                   in_data,
  input  logic                                cfg_we,
  input  logic [rwmc_pkg::SIZE_W-1:0]         cfg_wdata,
  output rwmc_pkg::out_res_t                  out_data
);

  localparam int CW = rwmc_pkg::COORD_W;
  localparam int SW = rwmc_pkg::SIZE_W;
  localparam int NW = rwmc_pkg::COUNT_W;
  localparam int HW = rwmc_pkg::HALF_W;
  localparam int MS = rwmc_pkg::MAX_SIZE;
  localparam int AW = rwmc_pkg::ROW_AW;

  // control-side registers
  logic [SW-1:0] grid_size_r;
  logic [CW-1:0] walker_row_r, walker_row_nxt;
  logic [CW-1:0] walker_col_r, walker_col_nxt;
  logic [NW-1:0] cells_left_r, cells_left_nxt;
  logic [MS-1:0] row_valid_r, row_valid_nxt;

  // captured request
  logic          op_r;
  logic [CW-1:0] tr_r, tc_r, mr_r, mc_r;
  rwmc_pkg::out_res_t out_data_r, out_data_nxt;

  logic [SW-1:0]   size;
  logic [CW-1:0]   tr, tc, mr, mc;
  logic [MS-1:0]   rd_data;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [MS-1:0]   ram_wdata;
  logic            hit;
  logic [HW-1:0]   half;
  logic [2*HW-1:0] half_sq;
  logic [CW-1:0]   start_col;

  // saturate the live size register into the legal range
  always_comb begin
    priority if (grid_size_r < SW'(rwmc_pkg::MIN_SIZE)) begin
      size = SW'(rwmc_pkg::MIN_SIZE);
    end else if (grid_size_r > SW'(MS)) begin
      size = SW'(MS);
    end else begin
      size = grid_size_r;
    end
  end

  assign start_col = CW'(size >> 1);
  assign half      = HW'(({1'b0, size} + (SW+1)'(1)) >> 1);
  assign half_sq   = half * half;

  // target and wall square of the move, or stay put
  always_comb begin
    tr = walker_row_r;
    tc = walker_col_r;
    mr = walker_row_r;
    mc = walker_col_r;
    unique case (rwmc_pkg::dir_t'(in_data.direction))
      rwmc_pkg::DIR_UP: begin
        if (walker_row_r >= CW'(rwmc_pkg::STRIDE)) begin
          tr = walker_row_r - CW'(rwmc_pkg::STRIDE);
          mr = walker_row_r - CW'(1);
        end
      end
      rwmc_pkg::DIR_RIGHT: begin
        if (({1'b0, walker_col_r} + SW'(rwmc_pkg::STRIDE)) < size) begin
          tc = walker_col_r + CW'(rwmc_pkg::STRIDE);
          mc = walker_col_r + CW'(1);
        end
      end
      rwmc_pkg::DIR_DOWN: begin
        if (({1'b0, walker_row_r} + SW'(rwmc_pkg::STRIDE)) < size) begin
          tr = walker_row_r + CW'(rwmc_pkg::STRIDE);
          mr = walker_row_r + CW'(1);
        end
      end
      rwmc_pkg::DIR_LEFT: begin
        if (walker_col_r >= CW'(rwmc_pkg::STRIDE)) begin
          tc = walker_col_r - CW'(rwmc_pkg::STRIDE);
          mc = walker_col_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // one row of the grid per word; wall squares never become targets, so only
  // cell squares are stored
  rwmc_ram #(
    .WIDTH (MS),
    .DEPTH (MS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (tr[AW-1:0]),
    .rdata (rd_data)
  );

  assign hit = row_valid_r[tr_r[AW-1:0]] & rd_data[tc_r[AW-1:0]];

  always_comb begin
    walker_row_nxt = walker_row_r;
    walker_col_nxt = walker_col_r;
    cells_left_nxt = cells_left_r;
    row_valid_nxt  = row_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = tr_r[AW-1:0];
    ram_wdata      = '0;
    out_data_nxt   = out_data_r;
    if (cmd.execute) begin
      out_data_nxt.carved   = 1'b0;
      out_data_nxt.wall_row = '0;
      out_data_nxt.wall_col = '0;
      if (op_r == rwmc_pkg::OP_RESTART) begin
        // stale rows read as empty once their valid bit drops
        row_valid_nxt    = '0;
        row_valid_nxt[0] = 1'b1;
        ram_we           = 1'b1;
        ram_waddr        = '0;
        ram_wdata        = MS'(1) << start_col[AW-1:0];
        walker_row_nxt   = '0;
        walker_col_nxt   = start_col;
        cells_left_nxt   = NW'(half_sq - (2*HW)'(1));
      end else if (cells_left_r != '0) begin
        if (!hit) begin
          row_valid_nxt[tr_r[AW-1:0]] = 1'b1;
          ram_we         = 1'b1;
          ram_wdata      = (row_valid_r[tr_r[AW-1:0]] ? rd_data : '0)
                           | (MS'(1) << tc_r[AW-1:0]);
          cells_left_nxt = cells_left_r - NW'(1);
          out_data_nxt.carved   = 1'b1;
          out_data_nxt.wall_row = mr_r;
          out_data_nxt.wall_col = mc_r;
        end
        walker_row_nxt = tr_r;
        walker_col_nxt = tc_r;
      end
      out_data_nxt.row       = walker_row_nxt;
      out_data_nxt.col       = walker_col_nxt;
      out_data_nxt.remaining = cells_left_nxt;
      out_data_nxt.done_res  = (cells_left_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= rwmc_pkg::GRID_SIZE_RESET;
      walker_row_r <= '0;
      walker_col_r <= rwmc_pkg::START_COL_RESET;
      cells_left_r <= '0;
      row_valid_r  <= '0;
    end else begin
      if (cfg_we) begin
        grid_size_r <= cfg_wdata;
      end
      walker_row_r <= walker_row_nxt;
      walker_col_r <= walker_col_nxt;
      cells_left_r <= cells_left_nxt;
      row_valid_r  <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_data.operation;
      tr_r <= tr;
      tc_r <= tc;
      mr_r <= mr;
      mc_r <= mc;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_data = out_data_r;

endmodule

// File: sv/random_walk_maze_carver.sv
// top level of the random walk maze carver
`timescale 1ns / 1ps

// Carves a maze on a square grid of side grid_size (saturated to 3..64) by a
// random walk whose directions the host supplies. A restart request empties
// the grid, puts the walker on row 0, column size/2 and loads the number of
// cells still to open; each step request, while that number is not zero,
// moves the walker two squares when that stays inside the grid, opening the
// target cell and the wall between if the cell was still closed. Every
// request returns exactly one result. The accept cycle reads the grid row of
// the target from a 64 x 64-bit single-port-read ram, and the check state,
// once the result register is free or draining, checks the bit, writes the
// row back and forms the result. There is no clearing pass: a valid flag per
// grid row drops on restart, so a restart takes the same states as a step.
// The result register lets the next request be accepted while the previous
// result still waits, though only once the check state is left. grid_size
// is read live and may only be written while no request is in flight.
module random_walk_maze_carver (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rwmc_pkg::in_req_t           in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output rwmc_pkg::out_res_t          out_data,
  // grid size register
  input  logic                        cfg_we,
  input  logic [rwmc_pkg::SIZE_W-1:0] cfg_wdata
);

  // commands from the sequencer to the datapath
  rwmc_pkg::ctrl_cmd_t cmd;

  rwmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // walker, count, grid store and result register
  rwmc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// File: sim/random_walk_maze_carver_checker.sv
// request and result checker for the random walk maze carver
`timescale 1ns / 1ps

module random_walk_maze_carver_checker
  import rwmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_req_t            in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_res_t           out_data,
  input  logic               cfg_we,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  // own copy of the carver state
  bit [MAX_SIZE*MAX_SIZE-1:0] cell_open;
  int unsigned                walk_row;
  int unsigned                walk_col;
  int unsigned                cells_to_open;
  logic [SIZE_W-1:0]          grid_size_q;

  out_res_t walk_results_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // one request moves the walker and returns the result it should report
  function automatic out_res_t carve_step(in_req_t req);
    int unsigned span, half, tr, tc, mr, mc;
    out_res_t    res;
    span = (grid_size_q < MIN_SIZE) ? MIN_SIZE :
           (grid_size_q > MAX_SIZE) ? MAX_SIZE : grid_size_q;
    res  = '0;
    if (req.operation == OP_RESTART) begin
      half          = (span + 1) / 2;
      cell_open     = '0;
      walk_row      = 0;
      walk_col      = span / 2;
      cell_open[walk_row * MAX_SIZE + walk_col] = 1'b1;
      cells_to_open = half * half - 1;
    end else if (cells_to_open != 0) begin
      tr = walk_row;
      tc = walk_col;
      mr = walk_row;
      mc = walk_col;
      case (req.direction)
        DIR_UP: if (walk_row >= STRIDE) begin
          tr = walk_row - STRIDE;
          mr = walk_row - 1;
        end
        DIR_RIGHT: if (walk_col + STRIDE < span) begin
          tc = walk_col + STRIDE;
          mc = walk_col + 1;
        end
        DIR_DOWN: if (walk_row + STRIDE < span) begin
          tr = walk_row + STRIDE;
          mr = walk_row + 1;
        end
        default: if (walk_col >= STRIDE) begin
          tc = walk_col - STRIDE;
          mc = walk_col - 1;
        end
      endcase
      if (!cell_open[tr * MAX_SIZE + tc]) begin
        cell_open[tr * MAX_SIZE + tc] = 1'b1;
        cell_open[mr * MAX_SIZE + mc] = 1'b1;
        cells_to_open--;
        res.carved   = 1'b1;
        res.wall_row = COORD_W'(mr);
        res.wall_col = COORD_W'(mc);
      end
      walk_row = tr;
      walk_col = tc;
    end
    res.row       = COORD_W'(walk_row);
    res.col       = COORD_W'(walk_col);
    res.remaining = COUNT_W'(cells_to_open);
    res.done_res  = (cells_to_open == 0);
    return res;
  endfunction

  task automatic flag_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      cell_open     = '0;
      walk_row      = 0;
      walk_col      = START_COL_RESET;
      cells_to_open = 0;
      grid_size_q   = GRID_SIZE_RESET;
      walk_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (walk_results_due.size() == 0) begin
          $display("%0t ns: result expected none, got %p", $time, out_data);
          mismatches++;
        end else begin
          want = walk_results_due.pop_front();
          flag_field("carved", want.carved, out_data.carved);
          flag_field("row", want.row, out_data.row);
          flag_field("col", want.col, out_data.col);
          flag_field("wall_row", want.wall_row, out_data.wall_row);
          flag_field("wall_col", want.wall_col, out_data.wall_col);
          flag_field("remaining", want.remaining, out_data.remaining);
          flag_field("done_res", want.done_res, out_data.done_res);
        end
      end
      if (in_valid && in_ready) walk_results_due.push_back(carve_step(in_data));
      if (cfg_we) grid_size_q = cfg_wdata;
    end
    pending = walk_results_due.size();
  end

endmodule

// File: sim/random_walk_maze_carver_tb.sv
// top of the random walk maze carver testbench: stimulus, idling and verdict
`timescale 1ns / 1ps

module random_walk_maze_carver_tb;
  import rwmc_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TARGET    = 1500;
  localparam int QUIET_TAIL     = 200;   // last requests go with no idling
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 16;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_ready;
  out_res_t          out_data;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent;
  int unsigned idle_cycles;
  bit          quiet;            // set near the end: no idling on either side
  bit          sender_idles;
  bit          receiver_stalls;

  always #(CLK_PERIOD / 2) clk = ~clk;

  random_walk_maze_carver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  random_walk_maze_carver_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // one request: maybe a random gap first, then hold valid until accepted
  task automatic send_request(input op_t op, input dir_t dir);
    in_req_t req;
    req.operation = op;
    req.direction = dir;
    if (!quiet && sender_idles && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // grid size is only written with nothing in flight
  task automatic write_grid_size(input logic [SIZE_W-1:0] size);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // receiver: ready drops in random bursts, none once the run goes quiet
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && receiver_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned        phase;
    int unsigned        steps;
    int unsigned        pick;
    logic [SIZE_W-1:0]  size;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = GRID_SIZE_RESET;
    sent            = 0;
    idle_cycles     = 0;
    quiet           = 1'b0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // steps before any restart: walker parked at its reset square, done set
    send_request(OP_STEP, DIR_UP);
    send_request(OP_STEP, DIR_RIGHT);
    send_request(OP_STEP, DIR_DOWN);
    send_request(OP_STEP, DIR_LEFT);

    // restart on the reset size, then a move off the top edge stays put
    send_request(OP_RESTART, DIR_LEFT);
    send_request(OP_STEP, DIR_UP);
    send_request(OP_STEP, DIR_LEFT);
    send_request(OP_STEP, DIR_RIGHT);

    // 5 x 5 grid walked to completion, then one step after the count hit zero
    write_grid_size(SIZE_W'(5));
    send_request(OP_RESTART, DIR_DOWN);
    send_request(OP_STEP, DIR_RIGHT);
    send_request(OP_STEP, DIR_DOWN);
    send_request(OP_STEP, DIR_DOWN);
    send_request(OP_STEP, DIR_LEFT);
    send_request(OP_STEP, DIR_LEFT);
    send_request(OP_STEP, DIR_UP);
    send_request(OP_STEP, DIR_UP);
    send_request(OP_STEP, DIR_DOWN);   // already open: no carve
    send_request(OP_STEP, DIR_RIGHT);  // last cell
    send_request(OP_STEP, DIR_LEFT);   // count is zero, nothing changes

    // random phases: new size, mostly a restart, then a run of steps;
    // the first phases hit the size extremes, small grids dominate so that
    // walks finish, and some phases keep walking across a size change
    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase)
        0: size = SIZE_W'(0);
        1: size = SIZE_W'(127);
        2: size = SIZE_W'(MAX_SIZE);
        3: size = SIZE_W'(MIN_SIZE);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0)      size = SIZE_W'($urandom_range(0, MIN_SIZE - 1));
          else if (pick == 1) size = SIZE_W'($urandom_range(MAX_SIZE + 1, 127));
          else if (pick == 2) size = SIZE_W'($urandom_range(13, MAX_SIZE));
          else                size = SIZE_W'($urandom_range(MIN_SIZE, 12));
        end
      endcase
      sender_idles    = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      write_grid_size(size);
      if (phase < 4 || $urandom_range(0, 6) != 0)
        send_request(OP_RESTART, dir_t'($urandom_range(0, 3)));
      steps = $urandom_range(20, 110);
      repeat (steps) begin
        if ($urandom_range(0, 24) == 0)
          send_request(OP_RESTART, dir_t'($urandom_range(0, 3)));
        else
          send_request(OP_STEP, dir_t'($urandom_range(0, 3)));
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
